FILE: src/amls5_pkg.sv
package amls5_pkg;

    // parse phases
    localparam logic [3:0] PH_SEARCH  = 4'd0;
    localparam logic [3:0] PH_PKGOP   = 4'd1;
    localparam logic [3:0] PH_PKGLEN  = 4'd2;
    localparam logic [3:0] PH_PKGSKIP = 4'd3;
    localparam logic [3:0] PH_COUNT   = 4'd4;
    localparam logic [3:0] PH_I1OP    = 4'd5;
    localparam logic [3:0] PH_I1FIRST = 4'd6;
    localparam logic [3:0] PH_I1REST  = 4'd7;
    localparam logic [3:0] PH_I2OP    = 4'd8;
    localparam logic [3:0] PH_I2FIRST = 4'd9;
    localparam logic [3:0] PH_I2REST  = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_NAME  = 3'd1;
    localparam logic [2:0] ST_NOT_PKG  = 3'd2;
    localparam logic [2:0] ST_FEW_ELEM = 3'd3;
    localparam logic [2:0] ST_BAD_INT  = 3'd4;

    // AML opcodes
    localparam logic [7:0] OP_PACKAGE = 8'h12;
    localparam logic [7:0] OP_ZERO    = 8'h00;
    localparam logic [7:0] OP_ONE     = 8'h01;
    localparam logic [7:0] OP_ONES    = 8'hFF;
    localparam logic [7:0] OP_BYTE    = 8'h0A;
    localparam logic [7:0] OP_WORD    = 8'h0B;
    localparam logic [7:0] OP_DWORD   = 8'h0C;
    localparam logic [7:0] OP_QWORD   = 8'h0E;

    localparam logic [31:0] NAME_S5    = 32'h5F53355F;
    localparam logic [15:0] ENABLE_BIT = 16'h2000;

    typedef struct packed {
        logic [23:0] recent;
        logic [3:0]  phase;
        logic [3:0]  skip;
        logic [5:0]  first;
        logic [5:0]  second;
        logic        given;
    } t_state;

    // parser state after reset
    localparam t_state STATE_RESET = {24'd0, PH_SEARCH, 4'd0, 6'd0, 6'd0, 1'b0};

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pm1a;
        logic [15:0] pm1b;
    } t_result;

endpackage

FILE: src/aml_s5_sleep_type_extractor_core.sv
// A byte accepted is held in the input stage register and processed when the
// result queue has room; its result, if any, is registered into the queue.
// Throughput: one byte per cycle unless the queue is full; a two-entry result
// queue lets input flow while a result waits to be taken.
// Reset (i_rst_n low at a clock edge) empties input stage and queue and
// returns the parser to name search.
module aml_s5_sleep_type_extractor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_table_byte,
    input  logic        i_end_of_table,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_pm1a_control,
    output logic [15:0] o_pm1b_control
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    amls5_pkg::t_state   r_state;
    amls5_pkg::t_state   n_state;
    amls5_pkg::t_result  r_q0;
    amls5_pkg::t_result  r_q1;
    logic [1:0]          r_cnt;
    amls5_pkg::t_result  step_result;
    logic                step_emit;
    logic                advance;
    logic                accept;
    logic                push;
    logic                pop;

    amls5_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    assign advance    = r_in_valid && (r_cnt != 2'd2);
    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;
    assign push       = advance && step_emit;
    assign pop        = (r_cnt != 2'd0) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= amls5_pkg::STATE_RESET;
        end else begin
            if (accept)       r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance)      r_state    <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_table_byte;
            r_in_last <= i_end_of_table;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // head in q0, second result in q1
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) r_q0 <= r_q1;
            else if (push)     r_q0 <= step_result;
        end else if (push) begin
            if (r_cnt == 2'd0) r_q0 <= step_result;
            else               r_q1 <= step_result;
        end
    end

    assign o_out_valid    = (r_cnt != 2'd0);
    assign o_status       = r_q0.status;
    assign o_pm1a_control = r_q0.pm1a;
    assign o_pm1b_control = r_q0.pm1b;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue overflow");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != amls5_pkg::ST_OK)
            |-> (o_pm1a_control == 16'd0 && o_pm1b_control == 16'd0))
        else $error("error result carries control words");

    a_ok_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == amls5_pkg::ST_OK)
            |-> (o_pm1a_control[13] && o_pm1b_control[13]))
        else $error("ok result without sleep enable");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_state.phase == amls5_pkg::PH_SEARCH
                                    && !r_state.given))
        else $error("parser not reset after end of table");

endmodule

FILE: src/amls5_step.sv
module amls5_step (
    input  amls5_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output amls5_pkg::t_state  o_state,
    output logic               o_emit,
    output amls5_pkg::t_result o_result
);

    amls5_pkg::t_state n_s;
    logic       err;
    logic       done;
    logic [2:0] err_status;
    logic       op_ok;
    logic       op_imm;
    logic [5:0] op_bits;
    logic [3:0] op_len;
    logic       second_int;

    always_comb begin
        op_ok   = 1'b1;
        op_imm  = 1'b1;
        op_bits = 6'd0;
        op_len  = 4'd0;
        case (i_byte)
            amls5_pkg::OP_ZERO:  op_bits = 6'd0;
            amls5_pkg::OP_ONE:   op_bits = 6'd1;
            amls5_pkg::OP_ONES:  op_bits = 6'h3F;
            amls5_pkg::OP_BYTE:  begin op_imm = 1'b0; op_len = 4'd1; end
            amls5_pkg::OP_WORD:  begin op_imm = 1'b0; op_len = 4'd2; end
            amls5_pkg::OP_DWORD: begin op_imm = 1'b0; op_len = 4'd4; end
            amls5_pkg::OP_QWORD: begin op_imm = 1'b0; op_len = 4'd8; end
            default:             op_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_s        = i_state;
        n_s.recent = {i_state.recent[15:0], i_byte};
        err        = 1'b0;
        done       = 1'b0;
        err_status = amls5_pkg::ST_BAD_INT;
        second_int = (i_state.phase == amls5_pkg::PH_I2OP)
                  || (i_state.phase == amls5_pkg::PH_I2FIRST)
                  || (i_state.phase == amls5_pkg::PH_I2REST);
        o_emit     = 1'b0;
        o_result   = '0;

        case (i_state.phase)
            amls5_pkg::PH_SEARCH: begin
                if ({i_state.recent, i_byte} == amls5_pkg::NAME_S5)
                    n_s.phase = amls5_pkg::PH_PKGOP;
            end
            amls5_pkg::PH_PKGOP: begin
                if (i_byte == amls5_pkg::OP_PACKAGE) begin
                    n_s.phase = amls5_pkg::PH_PKGLEN;
                end else begin
                    err        = 1'b1;
                    err_status = amls5_pkg::ST_NOT_PKG;
                end
            end
            amls5_pkg::PH_PKGLEN: begin
                n_s.skip  = {2'b00, i_byte[7:6]};
                n_s.phase = (i_byte[7:6] == 2'd0) ? amls5_pkg::PH_COUNT
                                                  : amls5_pkg::PH_PKGSKIP;
            end
            amls5_pkg::PH_PKGSKIP: begin
                n_s.skip = i_state.skip - 4'd1;
                if (i_state.skip == 4'd1)
                    n_s.phase = amls5_pkg::PH_COUNT;
            end
            amls5_pkg::PH_COUNT: begin
                if (i_byte < 8'd2) begin
                    err        = 1'b1;
                    err_status = amls5_pkg::ST_FEW_ELEM;
                end else begin
                    n_s.phase = amls5_pkg::PH_I1OP;
                end
            end
            amls5_pkg::PH_I1OP, amls5_pkg::PH_I2OP: begin
                if (!op_ok) begin
                    err = 1'b1;
                end else if (!op_imm) begin
                    n_s.skip  = op_len;
                    n_s.phase = second_int ? amls5_pkg::PH_I2FIRST
                                           : amls5_pkg::PH_I1FIRST;
                end else if (!second_int) begin
                    n_s.first = op_bits;
                    n_s.phase = amls5_pkg::PH_I2OP;
                end else begin
                    n_s.second = op_bits;
                    done       = 1'b1;
                end
            end
            amls5_pkg::PH_I1FIRST, amls5_pkg::PH_I2FIRST: begin
                if (second_int) n_s.second = i_byte[5:0];
                else            n_s.first  = i_byte[5:0];
                n_s.skip = i_state.skip - 4'd1;
                if (i_state.skip != 4'd1)
                    n_s.phase = second_int ? amls5_pkg::PH_I2REST
                                           : amls5_pkg::PH_I1REST;
                else if (!second_int)
                    n_s.phase = amls5_pkg::PH_I2OP;
                else
                    done = 1'b1;
            end
            amls5_pkg::PH_I1REST, amls5_pkg::PH_I2REST: begin
                n_s.skip = i_state.skip - 4'd1;
                if (i_state.skip == 4'd1) begin
                    if (!second_int) n_s.phase = amls5_pkg::PH_I2OP;
                    else             done = 1'b1;
                end
            end
            default: ;  // finished or unused: ignore bytes
        endcase

        if (err) begin
            o_emit          = 1'b1;
            o_result.status = err_status;
            n_s.given       = 1'b1;
            n_s.phase       = amls5_pkg::PH_DONE;
        end else if (done) begin
            o_emit          = 1'b1;
            o_result.status = amls5_pkg::ST_OK;
            o_result.pm1a   = {n_s.first, 10'd0} | amls5_pkg::ENABLE_BIT;
            o_result.pm1b   = {n_s.second, 10'd0} | amls5_pkg::ENABLE_BIT;
            n_s.given       = 1'b1;
            n_s.phase       = amls5_pkg::PH_DONE;
        end

        if (i_last) begin
            if (!o_emit && !i_state.given) begin
                o_emit          = 1'b1;
                o_result.status = (n_s.phase == amls5_pkg::PH_SEARCH)
                                ? amls5_pkg::ST_NO_NAME : amls5_pkg::ST_BAD_INT;
            end
            n_s       = '0;
            n_s.phase = amls5_pkg::PH_SEARCH;
        end

        o_state = n_s;
    end

endmodule
